// ===== src/sha1_pkg.sv =====
// shared types and constants of the sha-1 hash engine
`default_nettype none

package sha1_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = 5;
    localparam int NUM_ROUNDS = 80;

    // initial hash words, h0 in the lowest slot
    localparam logic [NUM_WORDS-1:0][WORD_W-1:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [WORD_W-1:0] K_00 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_20 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_40 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_60 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK       = 8'h80;
    localparam logic [5:0] LEN_POS        = 6'd56;   // 448 bits into a 512-bit block
    localparam logic [5:0] BLOCK_LAST_POS = 6'd63;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [2:0] WORD_LAST = 3'd4;

    typedef struct packed {
        logic       finish;
        logic [7:0] data;
    } cmd_t;

endpackage

`default_nettype wire

// ===== src/sha1_front.sv =====
// input stage: takes stream items and turns them into engine commands
`default_nettype none

module sha1_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [7:0]          s_tdata,   // [7:0] data_byte
    input  wire  [0:0]          s_tuser,   // [0] action
    output logic                cmd_valid,
    input  wire                 cmd_ready,
    output sha1_pkg::cmd_t      cmd
);

    logic           hold_valid_reg;
    logic           hold_valid_next;
    sha1_pkg::cmd_t hold_cmd_reg;
    sha1_pkg::cmd_t hold_cmd_next;
    logic           take;

    assign s_tready  = !hold_valid_reg || cmd_ready;
    assign take      = s_tvalid && s_tready;
    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_cmd_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (take) begin
            hold_valid_next      = 1'b1;
            hold_cmd_next.finish = (s_tuser[0] == sha1_pkg::ACT_FINISH);
            // a finish item carries no message byte
            hold_cmd_next.data   = (s_tuser[0] == sha1_pkg::ACT_FINISH) ? 8'h00 : s_tdata;
        end else if (cmd_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

`default_nettype wire

// ===== src/sha1_queue.sv =====
// command queue between the input stage and the hash engine
`default_nettype none

module sha1_queue #(
    parameter int DEPTH = 4
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  sha1_pkg::cmd_t      in_cmd,
    output logic                out_valid,
    input  wire                 out_ready,
    output sha1_pkg::cmd_t      out_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sha1_pkg::cmd_t   slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slots_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

`default_nettype wire

// ===== src/sha1_back.sv =====
// hash engine: byte packing, padding sequencer, 80-round compression, digest output
`default_nettype none

module sha1_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 q_valid,
    output logic                q_ready,
    input  sha1_pkg::cmd_t      q_cmd,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [31:0]         m_tdata,   // [31:0] digest_word
    output logic [2:0]          m_tuser,   // [2:0] word_index
    output logic                m_tlast    // last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [1:0] PH_MARK = 2'd0;
    localparam logic [1:0] PH_ZERO = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;

    localparam logic [6:0] RND_20   = 7'd20;
    localparam logic [6:0] RND_40   = 7'd40;
    localparam logic [6:0] RND_60   = 7'd60;
    localparam logic [6:0] RND_LAST = 7'(sha1_pkg::NUM_ROUNDS - 1);

    logic [2:0]   state_reg,     state_next;
    logic [1:0]   phase_reg,     phase_next;
    logic         pad_run_reg,   pad_run_next;
    logic         done_reg,      done_next;
    logic [6:0]   round_reg,     round_next;
    logic [2:0]   out_idx_reg,   out_idx_next;
    logic [63:0]  bit_count_reg, bit_count_next;
    logic [sha1_pkg::NUM_WORDS-1:0][31:0] hash_reg, hash_next;
    logic         m_valid_reg,   m_valid_next;

    // 64-byte window, oldest byte in the top bits; shifts by bytes while
    // absorbing and by words while expanding the schedule
    logic [511:0] blk_reg,       blk_next;
    logic [63:0]  len_reg,       len_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [31:0]  m_data_reg,    m_data_next;
    logic [2:0]   m_index_reg,   m_index_next;
    logic         m_last_reg,    m_last_next;

    logic [5:0]   pos;
    logic         take_cmd;
    logic         len_sel;
    logic [7:0]   len_byte;
    logic [7:0]   pad_byte;
    logic         absorb_en;
    logic [7:0]   absorb_byte;
    logic         block_full;
    logic         out_load;
    logic [31:0]  f_val;
    logic [31:0]  k_val;
    logic [31:0]  w_cur;
    logic [31:0]  w_mix;
    logic [31:0]  w_new;
    logic [31:0]  tmp;

    assign pos      = bit_count_reg[8:3];
    assign q_ready  = (state_reg == ST_IDLE);
    assign take_cmd = q_valid && q_ready;

    // length bytes go out most significant first at positions 56..63
    assign len_sel  = (phase_reg == PH_LEN) ||
                      ((phase_reg == PH_ZERO) && (pos == sha1_pkg::LEN_POS));
    assign len_byte = len_reg[{~pos[2:0], 3'b000} +: 8];
    assign pad_byte = (phase_reg == PH_MARK) ? sha1_pkg::PAD_MARK :
                      (len_sel ? len_byte : 8'h00);

    assign absorb_en   = (take_cmd && !q_cmd.finish) || (state_reg == ST_PAD);
    assign absorb_byte = (state_reg == ST_PAD) ? pad_byte : q_cmd.data;
    assign block_full  = absorb_en && (pos == sha1_pkg::BLOCK_LAST_POS);

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // round function
    always_comb begin
        if (round_reg < RND_20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1_pkg::K_00;
        end else if (round_reg < RND_40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K_20;
        end else if (round_reg < RND_60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1_pkg::K_40;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K_60;
        end
    end

    assign w_cur = blk_reg[511:480];
    assign w_mix = blk_reg[511:480] ^ blk_reg[447:416] ^ blk_reg[255:224] ^ blk_reg[95:64];
    assign w_new = {w_mix[30:0], w_mix[31]};
    assign tmp   = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pad_run_next   = pad_run_reg;
        done_next      = done_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;
        bit_count_next = bit_count_reg;
        hash_next      = hash_reg;
        blk_next       = blk_reg;
        len_next       = len_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        m_data_next    = m_data_reg;
        m_index_next   = m_index_reg;
        m_last_next    = m_last_reg;
        m_valid_next   = m_valid_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (take_cmd && q_cmd.finish) begin
                    len_next     = bit_count_reg;
                    phase_next   = PH_MARK;
                    pad_run_next = 1'b1;
                    state_next   = ST_PAD;
                end
            end
            ST_PAD: begin
                if (phase_reg == PH_MARK) begin
                    phase_next = PH_ZERO;
                end else if (len_sel) begin
                    phase_next = PH_LEN;
                end
                if (len_sel && (pos == sha1_pkg::BLOCK_LAST_POS)) begin
                    done_next = 1'b1;
                end
            end
            ST_ROUND: begin
                a_next   = tmp;
                b_next   = a_reg;
                c_next   = {b_reg[1:0], b_reg[31:2]};
                d_next   = c_reg;
                e_next   = d_reg;
                blk_next = {blk_reg[479:0], w_new};
                if (round_reg == RND_LAST) begin
                    round_next = '0;
                    state_next = ST_ADD;
                end else begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_ADD: begin
                hash_next[0] = hash_reg[0] + a_reg;
                hash_next[1] = hash_reg[1] + b_reg;
                hash_next[2] = hash_reg[2] + c_reg;
                hash_next[3] = hash_reg[3] + d_reg;
                hash_next[4] = hash_reg[4] + e_reg;
                if (done_reg) begin
                    state_next = ST_OUT;
                end else if (pad_run_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = hash_reg[out_idx_reg];
                    m_index_next = out_idx_reg;
                    m_last_next  = (out_idx_reg == sha1_pkg::WORD_LAST);
                    if (out_idx_reg == sha1_pkg::WORD_LAST) begin
                        out_idx_next   = '0;
                        hash_next      = sha1_pkg::H_INIT;
                        bit_count_next = '0;
                        pad_run_next   = 1'b0;
                        done_next      = 1'b0;
                        state_next     = ST_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // shared byte path for message and padding bytes
        if (absorb_en) begin
            blk_next       = {blk_reg[503:0], absorb_byte};
            bit_count_next = bit_count_reg + 64'd8;
            if (block_full) begin
                state_next = ST_ROUND;
                round_next = '0;
                a_next     = hash_reg[0];
                b_next     = hash_reg[1];
                c_next     = hash_reg[2];
                d_next     = hash_reg[3];
                e_next     = hash_reg[4];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_MARK;
            pad_run_reg   <= 1'b0;
            done_reg      <= 1'b0;
            round_reg     <= '0;
            out_idx_reg   <= '0;
            bit_count_reg <= '0;
            hash_reg      <= sha1_pkg::H_INIT;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pad_run_reg   <= pad_run_next;
            done_reg      <= done_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
            bit_count_reg <= bit_count_next;
            hash_reg      <= hash_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg     <= blk_next;
        len_reg     <= len_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        d_reg       <= d_next;
        e_reg       <= e_next;
        m_data_reg  <= m_data_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_index_reg;
    assign m_tlast  = m_last_reg;

    a_round_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= RND_LAST)
        else $error("round counter past last round");

    a_block_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND || state_reg == ST_ADD) |-> (pos == 6'd0))
        else $error("compression running on a partial block");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!done_reg && !pad_run_reg && round_reg == 7'd0))
        else $error("idle with padding or rounds pending");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_index_reg == sha1_pkg::WORD_LAST))
        else $error("last flag on a word other than h4");

endmodule

`default_nettype wire

// ===== src/sha1_hash_engine_core.sv =====
// top level of the streaming sha-1 hash engine
//
//  channel | dir | tdata                  | tuser             | tlast
//  s_      | in  | [7:0] data_byte        | [0] action        | -
//  m_      | out | [31:0] digest_word     | [2:0] word_index  | last_word
//
// a message byte is absorbed into the block window; each full 64-byte block then
// runs 80 rounds on the single round unit and a fold into h0..h4
// a finish item adds 9 to 72 padding bytes, runs one or two block compressions,
// and then puts out five words, one per cycle while m_tready stays high
// synchronous active-low reset returns h0..h4 to the initial values and
// clears the bit count; the command queue lets input items pile up while
// the engine compresses or waits on the output
`default_nettype none

module sha1_hash_engine_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire  [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    logic           fr_valid;
    logic           fr_ready;
    sha1_pkg::cmd_t fr_cmd;
    logic           q_valid;
    logic           q_ready;
    sha1_pkg::cmd_t q_cmd;

    sha1_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd       (fr_cmd)
    );

    sha1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_cmd    (fr_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    sha1_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for the streaming sha-1 hash engine, with its own digest predictor
`default_nettype none

module tb_top;

    typedef struct packed {
        sha1_pkg::cmd_t cmd;
        logic           drain;    // hold this item back until all digest words are out
    } pending_cmd_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_item_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    sha1_hash_engine_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // predictor state
    logic [31:0]  hash_h [sha1_pkg::NUM_WORDS];
    logic [31:0]  blk_w  [16];
    logic [63:0]  msg_bits;

    pending_cmd_t pending_cmds[$];
    digest_item_t digest_expect[$];
    pending_cmd_t next_cmd;
    digest_item_t want;
    int           taken_count = 0;
    int           seen_count  = 0;
    int           bad_count   = 0;
    bit           idle_on;

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic logic [31:0] rol_word(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void sha_restart();
        for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) hash_h[i] = sha1_pkg::H_INIT[i];
        msg_bits = '0;
    endfunction

    function automatic void sha_fold_block();
        logic [31:0] sched [16];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        sched = blk_w;
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int r = 0; r < sha1_pkg::NUM_ROUNDS; r++) begin
            if (r >= 16) begin
                sched[r % 16] = rol_word(sched[(r - 3) % 16] ^ sched[(r - 8) % 16] ^
                                         sched[(r - 14) % 16] ^ sched[r % 16], 1);
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K_00;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_20;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K_40;
            end else begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_60;
            end
            tmp = rol_word(a, 5) + f + e + k + sched[r % 16];
            e = d;
            d = c;
            c = rol_word(b, 30);
            b = a;
            a = tmp;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endfunction

    function automatic void sha_absorb(input logic [7:0] data);
        logic [5:0]  pos;
        logic [31:0] val;
        pos = msg_bits[8:3];
        val = {24'd0, data} << (24 - 8 * pos[1:0]);
        if (pos[1:0] == 2'd0) blk_w[pos[5:2]] = val;
        else                  blk_w[pos[5:2]] |= val;
        msg_bits += 64'd8;
        if (pos == sha1_pkg::BLOCK_LAST_POS) sha_fold_block();
    endfunction

    function automatic void sha_finish();
        logic [63:0]  len;
        digest_item_t item;
        len = msg_bits;
        sha_absorb(sha1_pkg::PAD_MARK);
        while (msg_bits[8:3] != sha1_pkg::LEN_POS) sha_absorb(8'd0);
        for (int i = 0; i < 8; i++) sha_absorb(len[63 - 8 * i -: 8]);
        for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) begin
            item.word = hash_h[i];
            item.idx  = 3'(i);
            item.last = (3'(i) == sha1_pkg::WORD_LAST);
            digest_expect.push_back(item);
        end
        sha_restart();
    endfunction

    task automatic push_cmd(input logic finish, input logic [7:0] data, input logic drain);
        pending_cmd_t p;
        p.cmd.finish = finish;
        p.cmd.data   = data;
        p.drain      = drain;
        pending_cmds.push_back(p);
    endtask

    // one stretch in the middle of the run with no idling, random idling on either side
    always_comb idle_on = !(taken_count >= 40 && taken_count < 80);

    // sender
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || taken_count != seen_count) begin
                if (pending_cmds.size() != 0 &&
                    !(pending_cmds[0].drain && digest_expect.size() != 0) &&
                    !(idle_on && $urandom_range(0, 99) < 14)) begin
                    next_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_cmd.cmd.data;
                    s_tuser  <= next_cmd.cmd.finish;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            seen_count = taken_count;
            m_tready <= !(idle_on && $urandom_range(0, 99) < 14);
        end
    end

    // input side: every accepted item goes through the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            taken_count++;
            if (s_tuser[0] == sha1_pkg::ACT_FINISH) sha_finish();
            else                                    sha_absorb(s_tdata);
        end
    end

    // result side
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_expect.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("unexpected digest word %h idx %0d last %b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = digest_expect.pop_front();
                if (m_tdata !== want.word || m_tuser !== want.idx || m_tlast !== want.last) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 want.word, want.idx, want.last, m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    initial begin
        int total;
        int len;
        int pick;
        aresetn = 1'b0;
        sha_restart();

        // empty message twice, finish data is ignored
        push_cmd(sha1_pkg::ACT_FINISH, 8'hFF, 1'b0);
        push_cmd(sha1_pkg::ACT_FINISH, 8'h00, 1'b0);
        push_cmd(sha1_pkg::ACT_ABSORB, 8'h00, 1'b0);
        push_cmd(sha1_pkg::ACT_FINISH, 8'h5A, 1'b0);
        push_cmd(sha1_pkg::ACT_ABSORB, 8'hFF, 1'b0);
        push_cmd(sha1_pkg::ACT_FINISH, 8'hA5, 1'b0);
        push_cmd(sha1_pkg::ACT_ABSORB, 8'h61, 1'b0);
        push_cmd(sha1_pkg::ACT_ABSORB, 8'h62, 1'b0);
        push_cmd(sha1_pkg::ACT_ABSORB, 8'h63, 1'b0);
        push_cmd(sha1_pkg::ACT_FINISH, 8'h00, 1'b0);
        push_cmd(sha1_pkg::ACT_ABSORB, 8'h80, 1'b0);
        push_cmd(sha1_pkg::ACT_ABSORB, 8'h7F, 1'b0);
        push_cmd(sha1_pkg::ACT_FINISH, 8'hFF, 1'b0);

        // random messages, lengths biased to the padding and block boundaries
        total = 0;
        while (total < 80) begin
            pick = $urandom_range(0, 15);
            if (pick < 11)       len = $urandom_range(0, 12);
            else if (pick < 13)  len = $urandom_range(55, 56);
            else if (pick == 13) len = $urandom_range(63, 64);
            else                 len = $urandom_range(13, 40);
            for (int i = 0; i < len; i++)
                push_cmd(sha1_pkg::ACT_ABSORB, 8'($urandom), (total == 0 && i == 0));
            push_cmd(sha1_pkg::ACT_FINISH, 8'($urandom), (total == 0 && len == 0));
            total += len + 1;
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid) @(posedge aclk);
        while (digest_expect.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (bad_count == 0 && digest_expect.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
